// ===== src/lcdbr_pkg.sv =====
// Shared constants, beat types and microcode table for the character LCD refresh block.
package lcdbr_pkg;

    // Display geometry
    localparam int COLUMNS = 20;
    localparam int ROWS    = 4;
    localparam int DEPTH   = ROWS * COLUMNS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int LINE_W  = 2;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Input kinds
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_CLEAR   = 2'd1;
    localparam logic [1:0] KIND_REFRESH = 2'd2;

    // Configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE0_CMD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE1_CMD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE2_CMD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE3_CMD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_WAIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_WAIT = 3'd5;

    localparam logic [7:0]  RST_LINE0_CMD = 8'h80;
    localparam logic [7:0]  RST_LINE1_CMD = 8'hC0;
    localparam logic [7:0]  RST_LINE2_CMD = 8'h94;
    localparam logic [7:0]  RST_LINE3_CMD = 8'hD4;
    localparam logic [15:0] RST_CMD_WAIT  = 16'd5000;
    localparam logic [15:0] RST_DATA_WAIT = 16'd240;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] row;
        logic [7:0] column;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic        reg_select;
        logic [3:0]  nibble;
        logic [15:0] wait_units;
        logic        frame_done;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [3:0][7:0] line_cmd;
        logic [15:0]     command_wait;
        logic [15:0]     data_wait;
    } t_cfg;

    // Microcode
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [STEP_W-1:0] ST_LD_CMD = 3'd1;
    localparam logic [STEP_W-1:0] ST_HI     = 3'd2;
    localparam logic [STEP_W-1:0] ST_LO     = 3'd3;
    localparam logic [STEP_W-1:0] ST_RD     = 3'd4;
    localparam logic [STEP_W-1:0] ST_LD_DAT = 3'd5;

    typedef enum logic [1:0] {
        EM_NONE = 2'd0,
        EM_HI   = 2'd1,
        EM_LO   = 2'd2
    } t_emit;

    typedef enum logic [1:0] {
        J_NEXT  = 2'd0,   // fall through
        J_GOTO  = 2'd1,   // always to target
        J_NOREF = 2'd2,   // to target unless a refresh beat was taken
        J_LAST  = 2'd3    // to target after the final character
    } t_jcond;

    typedef struct packed {
        logic              idle;
        logic              ld_cmd;
        logic              rd_mem;
        logic              ld_dat;
        t_emit             emit;
        t_jcond            jcond;
        logic [STEP_W-1:0] target;
    } t_ucode;

    typedef struct packed {
        logic out_free;
        logic last_col;
    } t_dp_status;

    function automatic t_ucode ucode_rom(input logic [STEP_W-1:0] step);
        t_ucode w;
        unique case (step)
            ST_IDLE:   w = '{1'b1, 1'b0, 1'b0, 1'b0, EM_NONE, J_NOREF, ST_IDLE};
            ST_LD_CMD: w = '{1'b0, 1'b1, 1'b0, 1'b0, EM_NONE, J_NEXT,  ST_IDLE};
            ST_HI:     w = '{1'b0, 1'b0, 1'b0, 1'b0, EM_HI,   J_NEXT,  ST_IDLE};
            ST_LO:     w = '{1'b0, 1'b0, 1'b0, 1'b0, EM_LO,   J_LAST,  ST_IDLE};
            ST_RD:     w = '{1'b0, 1'b0, 1'b1, 1'b0, EM_NONE, J_NEXT,  ST_IDLE};
            ST_LD_DAT: w = '{1'b0, 1'b0, 1'b0, 1'b1, EM_NONE, J_GOTO,  ST_HI};
            default:   w = '{1'b0, 1'b0, 1'b0, 1'b0, EM_NONE, J_GOTO,  ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== src/char_lcd_buffer_refresh_top.sv =====
// Top level of the character LCD buffer and 4-bit bus refresh block.
// Holds a ROWS x COLUMNS character buffer (spaces after reset and after a clear
// beat) and turns each refresh beat into the nibble stream for one display line:
// the line's set-address command, then every character of the line, each byte
// as high nibble (wait 0) then low nibble (command or data wait). Write and clear
// beats are taken while idle and give no output. A refresh runs from a small
// microcode table: one step to load the command byte, then one step per nibble
// and two steps per character (read, then load) to fetch it from the buffer. The
// input stays stalled from the refresh beat until the line's last nibble is
// emitted, and an emit step waits while the output side stalls. No new beat is
// taken while a refresh is running. Clearing is done through per-entry valid
// flags, so no clearing pass follows reset. The line pointer steps on each
// refresh and wraps after the last line, which sets frame_done on its final
// nibble. Configuration writes are always accepted (ready held high); indices
// above 5 are ignored.
module char_lcd_buffer_refresh_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input beats
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  lcdbr_pkg::t_in_item            i_in_item,
    // output beats
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output lcdbr_pkg::t_out_item           o_out_item,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lcdbr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lcdbr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    lcdbr_pkg::t_cfg       r_cfg;
    lcdbr_pkg::t_ucode     w_ctrl;
    lcdbr_pkg::t_dp_status w_status;
    logic                  w_in_accept;

    // beats are only taken in the idle step
    assign o_in_stall  = !w_ctrl.idle;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_cmd[0]  <= lcdbr_pkg::RST_LINE0_CMD;
            r_cfg.line_cmd[1]  <= lcdbr_pkg::RST_LINE1_CMD;
            r_cfg.line_cmd[2]  <= lcdbr_pkg::RST_LINE2_CMD;
            r_cfg.line_cmd[3]  <= lcdbr_pkg::RST_LINE3_CMD;
            r_cfg.command_wait <= lcdbr_pkg::RST_CMD_WAIT;
            r_cfg.data_wait    <= lcdbr_pkg::RST_DATA_WAIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lcdbr_pkg::CFG_LINE0_CMD: r_cfg.line_cmd[0]  <= i_cfg_data[7:0];
                lcdbr_pkg::CFG_LINE1_CMD: r_cfg.line_cmd[1]  <= i_cfg_data[7:0];
                lcdbr_pkg::CFG_LINE2_CMD: r_cfg.line_cmd[2]  <= i_cfg_data[7:0];
                lcdbr_pkg::CFG_LINE3_CMD: r_cfg.line_cmd[3]  <= i_cfg_data[7:0];
                lcdbr_pkg::CFG_CMD_WAIT:  r_cfg.command_wait <= i_cfg_data;
                lcdbr_pkg::CFG_DATA_WAIT: r_cfg.data_wait    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // step counter and control table
    lcdbr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_kind      (i_in_item.kind),
        .i_status    (w_status),
        .o_ctrl      (w_ctrl)
    );

    // buffer, byte staging and output register
    lcdbr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_cfg       (r_cfg),
        .i_in_accept (w_in_accept),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_status    (w_status)
    );

endmodule

// ===== src/lcdbr_seq.sv =====
// Microcode sequencer: step counter, control table lookup and conditional jumps.
module lcdbr_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_accept,
    input  logic [1:0]            i_kind,
    input  lcdbr_pkg::t_dp_status i_status,
    output lcdbr_pkg::t_ucode     o_ctrl
);

    logic [lcdbr_pkg::STEP_W-1:0] r_step;
    logic [lcdbr_pkg::STEP_W-1:0] n_step;
    lcdbr_pkg::t_ucode            w_ctrl;
    logic                         w_hold;
    logic                         w_refresh;

    assign w_ctrl    = lcdbr_pkg::ucode_rom(r_step);
    assign o_ctrl    = w_ctrl;
    // emit steps wait for the output register
    assign w_hold    = (w_ctrl.emit != lcdbr_pkg::EM_NONE) && !i_status.out_free;
    assign w_refresh = i_in_accept && (i_kind == lcdbr_pkg::KIND_REFRESH);

    always_comb begin
        n_step = r_step;
        if (!w_hold) begin
            unique case (w_ctrl.jcond)
                lcdbr_pkg::J_NEXT:  n_step = r_step + 1'b1;
                lcdbr_pkg::J_GOTO:  n_step = w_ctrl.target;
                lcdbr_pkg::J_NOREF: n_step = w_refresh ? r_step + 1'b1 : w_ctrl.target;
                lcdbr_pkg::J_LAST:  n_step = i_status.last_col ? w_ctrl.target
                                                               : r_step + 1'b1;
                default:            n_step = lcdbr_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= lcdbr_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== src/lcdbr_dp.sv =====
// Datapath: character buffer, byte/nibble staging, line pointer and output register.
module lcdbr_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lcdbr_pkg::t_ucode     i_ctrl,
    input  lcdbr_pkg::t_cfg       i_cfg,
    input  logic                  i_in_accept,
    input  lcdbr_pkg::t_in_item   i_in_item,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output lcdbr_pkg::t_out_item  o_out_item,
    output lcdbr_pkg::t_dp_status o_status
);

    // buffer
    logic [7:0]                   r_mem [lcdbr_pkg::DEPTH];
    logic [lcdbr_pkg::DEPTH-1:0]  r_vld;
    logic [7:0]                   r_rd_data;
    logic                         r_rd_vld;

    // byte being sent
    logic [7:0]                   r_byte;
    logic                         r_rs;
    logic [15:0]                  r_wait;
    logic [lcdbr_pkg::COL_W-1:0]  r_col;
    logic [lcdbr_pkg::LINE_W-1:0] r_line;
    logic                         r_frame;
    logic [lcdbr_pkg::LINE_W-1:0] r_ptr;

    logic                         r_out_vld;
    lcdbr_pkg::t_out_item         r_out_item;

    logic                         w_free;
    logic                         w_emit_go;
    logic                         w_lo_go;
    logic                         w_last;
    logic                         w_wr_en;
    logic                         w_clr_en;
    logic [lcdbr_pkg::LINE_W-1:0] w_wr_row;
    logic [lcdbr_pkg::COL_W-1:0]  w_wr_col;
    logic [lcdbr_pkg::ADDR_W-1:0] w_wr_addr;
    logic [lcdbr_pkg::ADDR_W-1:0] w_rd_addr;
    logic [lcdbr_pkg::LINE_W-1:0] w_cur_line;

    assign w_free    = !r_out_vld || !i_out_stall;
    assign w_emit_go = (i_ctrl.emit != lcdbr_pkg::EM_NONE) && w_free;
    assign w_lo_go   = (i_ctrl.emit == lcdbr_pkg::EM_LO) && w_free;
    assign w_last    = r_rs && (r_col == lcdbr_pkg::COL_W'(lcdbr_pkg::COLUMNS - 1));

    assign w_wr_en  = i_ctrl.idle && i_in_accept && (i_in_item.kind == lcdbr_pkg::KIND_WRITE);
    assign w_clr_en = i_ctrl.idle && i_in_accept && (i_in_item.kind == lcdbr_pkg::KIND_CLEAR);

    // out-of-range row or column folds to 0
    assign w_wr_row  = (int'(i_in_item.row) >= lcdbr_pkg::ROWS) ? '0
                     : i_in_item.row[lcdbr_pkg::LINE_W-1:0];
    assign w_wr_col  = (int'(i_in_item.column) >= lcdbr_pkg::COLUMNS) ? '0
                     : i_in_item.column[lcdbr_pkg::COL_W-1:0];
    assign w_wr_addr = lcdbr_pkg::ADDR_W'(int'(w_wr_row) * lcdbr_pkg::COLUMNS + int'(w_wr_col));
    assign w_rd_addr = lcdbr_pkg::ADDR_W'(int'(r_line) * lcdbr_pkg::COLUMNS + int'(r_col));

    assign w_cur_line = (int'(r_ptr) >= lcdbr_pkg::ROWS) ? '0 : r_ptr;

    assign o_out_valid       = r_out_vld;
    assign o_out_item        = r_out_item;
    assign o_status.out_free = w_free;
    assign o_status.last_col = w_last;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= i_in_item.char_code;
        end
        if (i_ctrl.rd_mem) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_vld  <= r_vld[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
            r_ptr     <= '0;
        end else begin
            if (w_clr_en) begin
                r_vld <= '0;
            end else if (w_wr_en) begin
                r_vld[w_wr_addr] <= 1'b1;
            end
            if (w_emit_go) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (w_lo_go && w_last) begin
                r_ptr <= r_frame ? '0 : r_line + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_cmd) begin
            r_line  <= w_cur_line;
            r_frame <= (int'(w_cur_line) == lcdbr_pkg::ROWS - 1);
            r_byte  <= i_cfg.line_cmd[w_cur_line];
            r_rs    <= 1'b0;
            r_wait  <= i_cfg.command_wait;
            r_col   <= '0;
        end
        if (i_ctrl.ld_dat) begin
            r_byte <= r_rd_vld ? r_rd_data : lcdbr_pkg::SPACE_CHAR;
            r_rs   <= 1'b1;
            r_wait <= i_cfg.data_wait;
        end
        if (w_emit_go) begin
            r_out_item.reg_select <= r_rs;
            if (i_ctrl.emit == lcdbr_pkg::EM_HI) begin
                r_out_item.nibble     <= r_byte[7:4];
                r_out_item.wait_units <= '0;
                r_out_item.frame_done <= 1'b0;
                r_out_item.last       <= 1'b0;
            end else begin
                r_out_item.nibble     <= r_byte[3:0];
                r_out_item.wait_units <= r_wait;
                r_out_item.frame_done <= w_last && r_frame;
                r_out_item.last       <= w_last;
            end
        end
        if (w_lo_go && r_rs) begin
            r_col <= r_col + 1'b1;
        end
    end

endmodule
